/* hdl/decimal_text_to_integer_unit_assert.svh */
// Assertion macros used by the checker file of the decimal text parser.
`ifndef DECIMAL_TEXT_TO_INTEGER_UNIT_ASSERT_SVH
`define DECIMAL_TEXT_TO_INTEGER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at each rising clock edge unless dis is high.
`define DTOI_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("dtoi assertion failed (same cycle)");

// Next-cycle implication, checked at each rising clock edge unless dis is high.
`define DTOI_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("dtoi assertion failed (next cycle)");

`endif

/* hdl/dtoi_pkg.sv */
// Types and character constants for the decimal text to integer parser.
package dtoi_pkg;

    localparam int unsigned CHAR_W  = 16;
    localparam int unsigned VALUE_W = 32;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 16'h0039;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 16'h002B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 16'h002D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] WIDE_MASK  = 16'hFF00;

    // One character beat held between the input register and the parser.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } item_t;

    // Per-field parse state.
    typedef struct packed {
        logic               in_body;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] acc_neg;
        logic               negate_flag;
        logic               forced_zero;
        logic               wide_pending;
    } parse_state_t;

    // Tab, line feed, vertical tab, form feed, carriage return and space.
    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

/* hdl/dtoi_in_stage.sv */
// Input register that holds one character beat until the parser takes it.
module dtoi_in_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [15:0]            s_axis_tdata,   // [15:0] char_code
    input  logic                   s_axis_tlast,   // is_last
    output logic                   item_valid,
    output dtoi_pkg::item_t        item,
    input  logic                   item_take
);

    logic            valid_reg;
    logic            valid_next;
    dtoi_pkg::item_t item_reg;

    // The register frees up in the same cycle that the parser takes its beat.
    assign s_axis_tready = !valid_reg || item_take;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg.char_code <= s_axis_tdata;
            item_reg.is_last   <= s_axis_tlast;
        end
    end

endmodule

/* hdl/dtoi_parse_core.sv */
// Parse state update, one char per cycle unless stalled, and the result register.
module dtoi_parse_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   signed_mode,
    input  logic                   item_valid,
    input  dtoi_pkg::item_t        item,
    output logic                   item_take,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata    // [31:0] value
);

    dtoi_pkg::parse_state_t st_reg;
    dtoi_pkg::parse_state_t st_next;
    dtoi_pkg::parse_state_t upd;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [31:0]            out_data_reg;
    logic [31:0]            result;
    logic [15:0]            c;
    logic                   c_wide;
    logic                   c_blank;
    logic                   c_digit;
    logic [31:0]            d;
    logic [31:0]            acc_x10;
    logic [31:0]            acc_neg_x10;
    logic                   out_free;

    assign c       = item.char_code;
    assign c_wide  = (c & dtoi_pkg::WIDE_MASK) != 16'h0000;
    assign c_blank = dtoi_pkg::is_blank(c);
    assign c_digit = (c >= dtoi_pkg::CHAR_ZERO) && (c <= dtoi_pkg::CHAR_NINE);
    assign d       = {28'd0, c[3:0]};

    // Times ten as shift and add; the negated copy avoids a negate after the add.
    assign acc_x10     = {st_reg.acc[28:0], 3'b000} + {st_reg.acc[30:0], 1'b0};
    assign acc_neg_x10 = {st_reg.acc_neg[28:0], 3'b000} + {st_reg.acc_neg[30:0], 1'b0};

    // A beat that ends a field needs room in the result register.
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign item_take = item_valid && (!item.is_last || out_free);

    // State after this character.
    always_comb begin
        upd = st_reg;
        if (!st_reg.forced_zero) begin
            if (!st_reg.in_body && c_wide) begin
                upd.forced_zero = 1'b1;
            end else if (!st_reg.in_body && c_blank) begin
                upd = st_reg;
            end else if (!st_reg.in_body && (c == dtoi_pkg::CHAR_PLUS)) begin
                upd.in_body = 1'b1;
            end else if (!st_reg.in_body && (c == dtoi_pkg::CHAR_MINUS)) begin
                upd.in_body = 1'b1;
                if (signed_mode) begin
                    upd.negate_flag = 1'b1;
                end else begin
                    upd.forced_zero = 1'b1;
                end
            end else begin
                // Body character, also the first one that is not a sign.
                upd.in_body = 1'b1;
                if (c_wide) begin
                    upd.wide_pending = 1'b1;
                end else if (c_blank) begin
                    upd.wide_pending = st_reg.wide_pending;
                end else if (c_digit) begin
                    upd.acc     = acc_x10 + d;
                    upd.acc_neg = acc_neg_x10 - d;
                end else begin
                    upd.acc          = 32'd0;
                    upd.acc_neg      = 32'd0;
                    upd.wide_pending = 1'b0;
                end
            end
        end
    end

    // Result of the field ending with this character.
    always_comb begin
        if (upd.forced_zero || upd.wide_pending) begin
            result = 32'd0;
        end else if (upd.negate_flag) begin
            result = upd.acc_neg;
        end else begin
            result = upd.acc;
        end
    end

    // Commit the state; a field end returns it to the cleared values.
    always_comb begin
        st_next = st_reg;
        if (item_take) begin
            if (item.is_last) begin
                st_next = '0;
            end else begin
                st_next = upd;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_take && item.is_last) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && item.is_last) begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* hdl/decimal_text_to_integer_unit.sv */
// Decimal text parser: character beats in, one 32-bit integer per field out.
// The block takes one character per cycle unless a field end waits for room
// in the result register, and gives one result beat for each beat marked
// with tlast. The result register loads at the same edge at which that beat
// leaves the input register. The rate is set by the accumulator update,
// a combinational times-ten shift-and-add. Leading whitespace is skipped,
// one '+' or '-' may follow, later whitespace is ignored, and any other
// ASCII non-digit restarts the number. A wide character (high byte nonzero)
// makes the result zero unless a later ASCII non-digit restarts the number;
// in the leading part it always does. With signed_mode low, a leading '-'
// gives zero. Overflow wraps modulo 2^32.
// cfg_wr_data is written into signed_mode when cfg_wr_en is high; reset sets
// signed_mode to 1. Write it only while no field is in progress.
module decimal_text_to_integer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,      // signed_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,     // [15:0] char_code
    input  logic        s_axis_tlast,     // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata      // [31:0] value
);

    logic            signed_mode_reg;
    logic            item_valid;
    logic            item_take;
    dtoi_pkg::item_t item;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            signed_mode_reg <= cfg_wr_data;
        end
    end

    dtoi_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    dtoi_parse_core u_parse_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .signed_mode   (signed_mode_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* hdl/dtoi_checker.sv */
// Port-level checks for the decimal text parser and their bind to the top level.
`include "decimal_text_to_integer_unit_assert.svh"

module dtoi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result beat stays valid and keeps its value.
    `DTOI_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Reset leaves no result pending.
    `DTOI_ASSERT_NEXT(a_reset_clears_out, aclk, 1'b0, !aresetn, !m_axis_tvalid)

    // With the result register empty, the input side is never stalled.
    `DTOI_ASSERT_SAME(a_ready_when_out_empty, aclk, !aresetn, !m_axis_tvalid, s_axis_tready)

endmodule

bind decimal_text_to_integer_unit dtoi_checker u_dtoi_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
